### hw/rtl/lffs_pkg.sv
// shared types and constants for the led flash/fade sequencer
package lffs_pkg;

  localparam int unsigned FRAME_MS_DEF = 31;

  localparam int unsigned COLOR_W = 32;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned STEP_W  = 9;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DIV_W   = 17;

  localparam logic [MODE_W-1:0] MODE_STEADY = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FLASH  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FADE   = 2'd2;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_COLORA = 3'd1;
  localparam logic [2:0] REG_COLORB = 3'd2;
  localparam logic [2:0] REG_REPEAT = 3'd3;
  localparam logic [2:0] REG_ONTIME = 3'd4;
  localparam logic [2:0] REG_OFFTIM = 3'd5;

  typedef enum logic [1:0] {
    OP_CH0 = 2'd0,
    OP_CH1 = 2'd1,
    OP_CH2 = 2'd2
  } op_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    op_t  div_op;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode_sel;
    logic              div_done;
    logic              out_free;
  } sts_t;

endpackage

### hw/rtl/lffs_div.sv
// restoring divider, one quotient bit per cycle
module lffs_div #(
  parameter int unsigned W = lffs_pkg::DIV_W
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] quot
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    rem_sh;
  logic [W:0]    rem_sub;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r, q_r[W-1]};
    rem_sub  = rem_sh - {1'b0, den_r};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = rem_sub[W-1:0];
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[W-1:0];
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;

endmodule

### hw/rtl/lffs_datapath.sv
// config registers, animation state, step divider and output register
module lffs_datapath #(
  parameter int unsigned FRAME_MS = lffs_pkg::FRAME_MS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lffs_pkg::cmd_t               cmd,
  output lffs_pkg::sts_t               sts,
  input  logic                         in_restart,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lffs_pkg::COLOR_W-1:0] out_pixel_color,
  output logic [lffs_pkg::MODE_W-1:0]  out_mode_now,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lffs_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata
);

  localparam int unsigned CW = lffs_pkg::COLOR_W;
  localparam int unsigned NW = lffs_pkg::CNT_W;
  localparam int unsigned MW = lffs_pkg::MODE_W;
  localparam int unsigned SW = lffs_pkg::STEP_W;
  localparam int unsigned DW = lffs_pkg::DIV_W;
  localparam int unsigned PW = 2 * NW + 1;
  // ms to frames: exact floor division of a 16-bit count by multiply and shift
  localparam int unsigned FRAME_SH = NW + $clog2(FRAME_MS);
  localparam logic [NW:0] FRAME_RECIP =
    (NW+1)'(((64'd1 << FRAME_SH) + 64'(FRAME_MS) - 64'd1) / 64'(FRAME_MS));

  // configuration
  logic [MW-1:0] mode_sel_r;
  logic [CW-1:0] color_a_r;
  logic [CW-1:0] color_b_r;
  logic [NW-1:0] repeat_r;
  logic [NW-1:0] on_time_r;
  logic [NW-1:0] off_time_r;
  logic [2:0]    reg_idx;
  logic          cfg_wr;

  // animation state
  logic [MW-1:0]        mode_r, mode_nxt;
  logic [NW-1:0]        frame_idx_r, frame_idx_nxt;
  logic [NW-1:0]        cycles_r, cycles_nxt;
  logic                 up_r, up_nxt;
  logic [23:0]          fade_color_r, fade_color_nxt;
  logic signed [SW-1:0] ch_step_r [3];
  logic [CW-1:0]        steady_r, steady_nxt;
  logic [CW-1:0]        off_color_r, off_color_nxt;
  logic [NW-1:0]        on_frames_r;
  logic [NW:0]          on_off_r;
  logic [NW-1:0]        fade_steps_r;
  logic                 restart_r;

  logic [CW-1:0] out_pix_r, out_pix_nxt;
  logic [MW-1:0] out_mode_r;
  logic          out_valid_r;
  logic          out_free;

  // frame counts from the configured times
  logic [PW-1:0] on_prod, off_prod;
  logic [NW-1:0] on_q, off_q;

  // divider hookup
  logic [DW-1:0] div_num, div_den, div_quot;
  logic          div_busy, div_done;
  logic [7:0]    ch_a, ch_b;
  logic [8:0]    ch_diff;
  logic [8:0]    ch_mag;
  logic          ch_neg;
  logic [8:0]    q_mag;
  logic [SW-1:0] q_step;
  logic [NW-1:0] fi_inc;

  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (reg_idx)
      lffs_pkg::REG_MODE:   prdata = {30'd0, mode_sel_r};
      lffs_pkg::REG_COLORA: prdata = color_a_r;
      lffs_pkg::REG_COLORB: prdata = color_b_r;
      lffs_pkg::REG_REPEAT: prdata = {16'd0, repeat_r};
      lffs_pkg::REG_ONTIME: prdata = {16'd0, on_time_r};
      lffs_pkg::REG_OFFTIM: prdata = {16'd0, off_time_r};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_sel_r <= '0;
      color_a_r  <= '0;
      color_b_r  <= '0;
      repeat_r   <= '0;
      on_time_r  <= '0;
      off_time_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        lffs_pkg::REG_MODE:   mode_sel_r <= pwdata[MW-1:0];
        lffs_pkg::REG_COLORA: color_a_r  <= pwdata;
        lffs_pkg::REG_COLORB: color_b_r  <= pwdata;
        lffs_pkg::REG_REPEAT: repeat_r   <= pwdata[NW-1:0];
        lffs_pkg::REG_ONTIME: on_time_r  <= pwdata[NW-1:0];
        lffs_pkg::REG_OFFTIM: off_time_r <= pwdata[NW-1:0];
        default: ;
      endcase
    end
  end

  assign on_prod  = PW'(on_time_r) * PW'(FRAME_RECIP);
  assign off_prod = PW'(off_time_r) * PW'(FRAME_RECIP);
  assign on_q     = NW'(on_prod >> FRAME_SH);
  assign off_q    = NW'(off_prod >> FRAME_SH);

  // channel operands for the rounded step division
  always_comb begin
    case (cmd.div_op)
      lffs_pkg::OP_CH0: begin
        ch_a = color_a_r[23:16];
        ch_b = color_b_r[23:16];
      end
      lffs_pkg::OP_CH1: begin
        ch_a = color_a_r[15:8];
        ch_b = color_b_r[15:8];
      end
      default: begin
        ch_a = color_a_r[7:0];
        ch_b = color_b_r[7:0];
      end
    endcase
    ch_diff = {1'b0, ch_b} - {1'b0, ch_a};
    ch_neg  = ch_diff[8];
    ch_mag  = ch_neg ? (9'd0 - ch_diff) : ch_diff;
    // (2*|d| + n) / (2*n) rounds half away from zero
    div_num = DW'({ch_mag[7:0], 1'b0}) + {1'b0, fade_steps_r};
    div_den = {fade_steps_r, 1'b0};
    q_mag  = {1'b0, div_quot[7:0]};
    q_step = ch_neg ? (9'd0 - q_mag) : q_mag;
  end

  lffs_div #(
    .W (DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign out_free = !out_valid_r || !out_stall;

  // frame update, applied on finish
  always_comb begin
    logic                 rev;
    logic                 up_use;
    logic [NW-1:0]        cyc_dec;
    logic [NW-1:0]        fi_base;
    logic [7:0]           fc;
    logic signed [SW-1:0] st;
    logic [9:0]           dd;
    logic [9:0]           ss;
    logic [23:0]          fout;

    mode_nxt       = mode_r;
    frame_idx_nxt  = frame_idx_r;
    cycles_nxt     = cycles_r;
    up_nxt         = up_r;
    fade_color_nxt = fade_color_r;
    steady_nxt     = steady_r;
    off_color_nxt  = off_color_r;
    out_pix_nxt    = '0;
    fi_inc         = frame_idx_r + 1'b1;
    cyc_dec        = cycles_r - 1'b1;
    rev            = (frame_idx_r >= fade_steps_r);
    up_use         = rev ? !up_r : up_r;
    fi_base        = rev ? '0 : frame_idx_r;
    fout           = '0;
    for (int k = 0; k < 3; k++) begin
      fc = fade_color_r[16-8*k +: 8];
      st = ch_step_r[k];
      dd = up_use ? {st[SW-1], st} : (10'd0 - {st[SW-1], st});
      ss = {2'b00, fc} + dd;
      if (ss[9]) begin
        fout[16-8*k +: 8] = 8'd0;
      end else if (ss[8]) begin
        fout[16-8*k +: 8] = 8'd255;
      end else begin
        fout[16-8*k +: 8] = ss[7:0];
      end
    end

    if (restart_r) begin
      frame_idx_nxt = '0;
      if (mode_sel_r == lffs_pkg::MODE_FLASH) begin
        cycles_nxt    = repeat_r;
        steady_nxt    = color_a_r;
        off_color_nxt = color_b_r;
        mode_nxt      = (repeat_r != '0) ? lffs_pkg::MODE_FLASH : lffs_pkg::MODE_STEADY;
      end else if (mode_sel_r == lffs_pkg::MODE_FADE) begin
        up_nxt         = 1'b1;
        cycles_nxt     = repeat_r;
        fade_color_nxt = color_a_r[23:0];
        mode_nxt       = lffs_pkg::MODE_FADE;
      end else begin
        steady_nxt = color_a_r;
        mode_nxt   = lffs_pkg::MODE_STEADY;
      end
    end else if (mode_r == lffs_pkg::MODE_FLASH) begin
      frame_idx_nxt = fi_inc;
      if (fi_inc <= on_frames_r) begin
        out_pix_nxt = steady_r;
      end else if ({1'b0, fi_inc} <= on_off_r) begin
        out_pix_nxt = off_color_r;
      end else begin
        // wrap frame: black, one cycle used up
        cycles_nxt    = cyc_dec;
        frame_idx_nxt = '0;
        if (cyc_dec == '0) begin
          mode_nxt   = lffs_pkg::MODE_STEADY;
          steady_nxt = '0;
        end
      end
    end else if (mode_r == lffs_pkg::MODE_FADE) begin
      up_nxt         = up_use;
      frame_idx_nxt  = fi_base + 1'b1;
      fade_color_nxt = fout;
      out_pix_nxt    = {8'd0, fout};
      if (rev) begin
        cycles_nxt = cyc_dec;
        if (cyc_dec == '0) begin
          mode_nxt   = lffs_pkg::MODE_STEADY;
          steady_nxt = '0;
        end
      end
    end else begin
      out_pix_nxt = steady_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= lffs_pkg::MODE_STEADY;
      frame_idx_r  <= '0;
      cycles_r     <= '0;
      up_r         <= 1'b1;
      fade_color_r <= '0;
      ch_step_r[0] <= '0;
      ch_step_r[1] <= '0;
      ch_step_r[2] <= '0;
      steady_r     <= '0;
      off_color_r  <= '0;
      on_frames_r  <= '0;
      on_off_r     <= '0;
      fade_steps_r <= '0;
      restart_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.accept) begin
        restart_r <= in_restart;
        // frame counts are taken when a restart is accepted
        if (in_restart) begin
          if (mode_sel_r == lffs_pkg::MODE_FLASH) begin
            on_frames_r <= on_q;
            on_off_r    <= {1'b0, on_q} + {1'b0, off_q};
          end else if (mode_sel_r == lffs_pkg::MODE_FADE) begin
            // zero steps counts as one
            fade_steps_r <= (on_q == '0) ? NW'(1) : on_q;
          end
        end
      end
      if (div_done) begin
        case (cmd.div_op)
          lffs_pkg::OP_CH0: ch_step_r[0] <= q_step;
          lffs_pkg::OP_CH1: ch_step_r[1] <= q_step;
          lffs_pkg::OP_CH2: ch_step_r[2] <= q_step;
          default: ;
        endcase
      end
      if (cmd.finish) begin
        mode_r       <= mode_nxt;
        frame_idx_r  <= frame_idx_nxt;
        cycles_r     <= cycles_nxt;
        up_r         <= up_nxt;
        fade_color_r <= fade_color_nxt;
        steady_r     <= steady_nxt;
        off_color_r  <= off_color_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_pix_r  <= out_pix_nxt;
      out_mode_r <= mode_nxt;
    end
  end

  assign sts.mode_sel = mode_sel_r;
  assign sts.div_done = div_done;
  assign sts.out_free = out_free;

  assign out_valid       = out_valid_r;
  assign out_pixel_color = out_pix_r;
  assign out_mode_now    = out_mode_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("divider started while busy");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> out_free)
    else $error("result written over a pending transfer");

  a_flash_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == lffs_pkg::MODE_FLASH) |-> (cycles_r != '0))
    else $error("flash running with no cycles left");

  a_fade_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == lffs_pkg::MODE_FADE) |-> (fade_steps_r != '0))
    else $error("fade running with zero steps");

endmodule

### hw/rtl/lffs_ctrl.sv
// sequencing fsm: accept, restart divisions, frame commit
module lffs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_restart,
  output logic           in_stall,
  output lffs_pkg::cmd_t cmd,
  input  lffs_pkg::sts_t sts
);

  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_DIV_GO   = 4'b0010,
    ST_DIV_WAIT = 4'b0100,
    ST_FINISH   = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  lffs_pkg::op_t   op_r, op_nxt;
  logic            accept;
  logic            is_fade;

  assign is_fade  = (sts.mode_sel == lffs_pkg::MODE_FADE);
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_restart && is_fade) begin
            op_nxt    = lffs_pkg::OP_CH0;
            state_nxt = ST_DIV_GO;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_DIV_GO: begin
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          state_nxt = ST_DIV_GO;
          case (op_r)
            lffs_pkg::OP_CH0: op_nxt = lffs_pkg::OP_CH1;
            lffs_pkg::OP_CH1: op_nxt = lffs_pkg::OP_CH2;
            default:          state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= lffs_pkg::OP_CH0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  assign cmd.accept    = accept;
  assign cmd.div_start = (state_r == ST_DIV_GO);
  assign cmd.div_op    = op_r;
  assign cmd.finish    = (state_r == ST_FINISH) && sts.out_free;

endmodule

### hw/rtl/led_flash_fade_sequencer.sv
// top level of the led flash/fade sequencer
// Each input transfer is one frame tick and yields one color transfer. A
// plain frame in any mode, and a steady or flash restart, goes from
// acceptance straight to the finish state; flash frame counts come from a
// multiply by the reciprocal of the frame period. A fade restart runs the
// three channel step divisions in turn through one shared restoring divider,
// 17 quotient bits per division. One frame is in work at a time; a finished
// result sits in the output register so the next tick can be taken while it
// waits.
module led_flash_fade_sequencer #(
  parameter int unsigned FRAME_MS = lffs_pkg::FRAME_MS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_restart,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lffs_pkg::COLOR_W-1:0] out_pixel_color,
  output logic [lffs_pkg::MODE_W-1:0]  out_mode_now,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lffs_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  lffs_pkg::cmd_t cmd;
  lffs_pkg::sts_t sts;

  assign pready = 1'b1;

  lffs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_restart (in_restart),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .sts        (sts)
  );

  lffs_datapath #(
    .FRAME_MS (FRAME_MS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_color (out_pixel_color),
    .out_mode_now    (out_mode_now),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata)
  );

endmodule

### tb/lffs_frame_checker.sv
// checker for the led flash/fade sequencer: predicts each frame color and compares
`timescale 1ns / 100ps

module lffs_frame_checker #(
  parameter int unsigned FRAME_MS = lffs_pkg::FRAME_MS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         in_restart,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [lffs_pkg::COLOR_W-1:0] out_pixel_color,
  input  logic [lffs_pkg::MODE_W-1:0]  out_mode_now,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [lffs_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output int                           mismatches,
  output int                           frames_pending
);

  typedef struct packed {
    logic [lffs_pkg::COLOR_W-1:0] pixel;
    logic [lffs_pkg::MODE_W-1:0]  mode;
  } frame_result_t;

  // register copies
  logic [lffs_pkg::MODE_W-1:0]  sel_r;
  logic [lffs_pkg::COLOR_W-1:0] col_a_r, col_b_r;
  logic [15:0]                  rep_r, on_ms_r, off_ms_r;

  // animation state
  logic [lffs_pkg::MODE_W-1:0]  mode_q;
  logic [15:0]                  frame_idx, cycles_left, on_frames, fade_steps;
  logic [16:0]                  on_off_frames;
  logic                         fade_up;
  logic [23:0]                  fade_rgb;
  logic signed [8:0]            chan_step [3];
  logic [lffs_pkg::COLOR_W-1:0] on_color, off_color;

  frame_result_t expected_colors [$];
  int result_no;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 40)
      $display("mismatch on result %0d: %s got %h expected %h", result_no, field, got, want);
    mismatches++;
  endtask

  function automatic logic signed [8:0] rounded_step(int num, int den);
    int mag, q;
    mag = num < 0 ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return num < 0 ? 9'(-q) : 9'(q);
  endfunction

  function automatic void go_black();
    mode_q = lffs_pkg::MODE_STEADY;
    on_color = '0;
    frame_idx = '0;
  endfunction

  function automatic frame_result_t next_frame_color(logic restart);
    frame_result_t res;
    int sh, c1, c2, sum, quot;
    logic [23:0] faded;
    res.pixel = '0;
    if (restart) begin
      frame_idx = '0;
      if (sel_r == lffs_pkg::MODE_FLASH) begin
        cycles_left = rep_r;
        on_frames = 16'(on_ms_r / FRAME_MS);
        on_off_frames = 17'(off_ms_r / FRAME_MS) + 17'(on_frames);
        on_color = col_a_r;
        off_color = col_b_r;
        mode_q = rep_r != 0 ? lffs_pkg::MODE_FLASH : lffs_pkg::MODE_STEADY;
      end else if (sel_r == lffs_pkg::MODE_FADE) begin
        quot = on_ms_r / FRAME_MS;
        fade_steps = quot == 0 ? 16'd1 : 16'(quot);
        fade_up = 1'b1;
        cycles_left = rep_r;
        fade_rgb = col_a_r[23:0];
        for (int k = 0; k < 3; k++) begin
          sh = 16 - 8 * k;
          c1 = int'(col_a_r[sh +: 8]);
          c2 = int'(col_b_r[sh +: 8]);
          chan_step[k] = rounded_step(c2 - c1, int'(fade_steps));
        end
        mode_q = lffs_pkg::MODE_FADE;
      end else begin
        // the unused selector behaves as steady
        on_color = col_a_r;
        mode_q = lffs_pkg::MODE_STEADY;
      end
    end else if (mode_q == lffs_pkg::MODE_FLASH) begin
      frame_idx = frame_idx + 16'd1;
      if (frame_idx <= on_frames) begin
        res.pixel = on_color;
      end else if ({1'b0, frame_idx} <= on_off_frames) begin
        res.pixel = off_color;
      end else begin
        // wrap frame is black and uses up one cycle
        cycles_left = cycles_left - 16'd1;
        frame_idx = '0;
        if (cycles_left == 0) go_black();
      end
    end else if (mode_q == lffs_pkg::MODE_FADE) begin
      if (frame_idx >= fade_steps) begin
        fade_up = !fade_up;
        frame_idx = '0;
        cycles_left = cycles_left - 16'd1;
        if (cycles_left == 0) go_black();
      end
      // the step is still applied on the frame that runs out
      for (int k = 0; k < 3; k++) begin
        sh = 16 - 8 * k;
        sum = int'(fade_rgb[sh +: 8]) + (fade_up ? int'(chan_step[k]) : -int'(chan_step[k]));
        faded[sh +: 8] = sum < 0 ? 8'd0 : (sum > 255 ? 8'd255 : 8'(sum));
      end
      fade_rgb = faded;
      frame_idx = frame_idx + 16'd1;
      res.pixel = {8'h00, faded};
    end else begin
      res.pixel = on_color;
    end
    res.mode = mode_q;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    frame_result_t want;
    if (!rst_n) begin
      sel_r = '0; col_a_r = '0; col_b_r = '0;
      rep_r = '0; on_ms_r = '0; off_ms_r = '0;
      mode_q = lffs_pkg::MODE_STEADY; frame_idx = '0; cycles_left = '0;
      fade_up = 1'b1; fade_rgb = '0;
      for (int k = 0; k < 3; k++) chan_step[k] = '0;
      on_color = '0; off_color = '0;
      on_frames = '0; on_off_frames = '0; fade_steps = '0;
      expected_colors.delete();
      result_no = 0;
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          lffs_pkg::REG_MODE:   sel_r = pwdata[lffs_pkg::MODE_W-1:0];
          lffs_pkg::REG_COLORA: col_a_r = pwdata;
          lffs_pkg::REG_COLORB: col_b_r = pwdata;
          lffs_pkg::REG_REPEAT: rep_r = pwdata[15:0];
          lffs_pkg::REG_ONTIME: on_ms_r = pwdata[15:0];
          lffs_pkg::REG_OFFTIM: off_ms_r = pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_colors.push_back(next_frame_color(in_restart));
      if (out_valid && !out_stall) begin
        if (expected_colors.size() == 0) begin
          report_mismatch("unexpected transfer, pixel", out_pixel_color, '0);
        end else begin
          want = expected_colors.pop_front();
          if (out_pixel_color !== want.pixel)
            report_mismatch("pixel_color", out_pixel_color, want.pixel);
          if (out_mode_now !== want.mode)
            report_mismatch("mode_now", 32'(out_mode_now), 32'(want.mode));
        end
        result_no++;
      end
    end
    frames_pending <= expected_colors.size();
  end

endmodule

### tb/led_flash_fade_sequencer_tb.sv
// top of the led flash/fade sequencer testbench: stimulus, idling and verdict
`timescale 1ns / 100ps

module led_flash_fade_sequencer_tb;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_restart = 1'b0;
  logic                          in_stall;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [lffs_pkg::COLOR_W-1:0]  out_pixel_color;
  logic [lffs_pkg::MODE_W-1:0]   out_mode_now;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [lffs_pkg::ADDR_W-1:0]   paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  int mismatches;
  int frames_pending;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  led_flash_fade_sequencer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_color (out_pixel_color),
    .out_mode_now    (out_mode_now),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  lffs_frame_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_color (out_pixel_color),
    .out_mode_now    (out_mode_now),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .mismatches      (mismatches),
    .frames_pending  (frames_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || psel || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_frame(input logic restart);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic configure(input logic [1:0] sel, input logic [31:0] col_a,
                           input logic [31:0] col_b, input logic [15:0] rep,
                           input logic [15:0] on_ms, input logic [15:0] off_ms);
    drain();
    write_reg(lffs_pkg::REG_MODE, 32'(sel));
    write_reg(lffs_pkg::REG_COLORA, col_a);
    write_reg(lffs_pkg::REG_COLORB, col_b);
    write_reg(lffs_pkg::REG_REPEAT, 32'(rep));
    write_reg(lffs_pkg::REG_ONTIME, 32'(on_ms));
    write_reg(lffs_pkg::REG_OFFTIM, 32'(off_ms));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_frames(input int n);
    for (int i = 0; i < n; i++) send_frame($urandom_range(24) == 0);
  endtask

  function automatic logic [31:0] rand_color();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_ms();
    case ($urandom_range(11))
      0: return 16'hFFFF;
      1: return 16'd0;
      default: return 16'($urandom_range(200));
    endcase
  endfunction

  function automatic logic [15:0] rand_repeat();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(1, 4));
    endcase
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // steady black out of reset, then a steady restart
    send_frame(1'b0);
    configure(lffs_pkg::MODE_STEADY, 32'hFFFF_FFFF, 32'h0, 16'd0, 16'd0, 16'd0);
    send_frame(1'b0);
    send_frame(1'b1);
    send_frame(1'b0);
    // flash, one on frame and one off frame, a repeat count of two, then black
    configure(lffs_pkg::MODE_FLASH, 32'h0012_3456, 32'hFF00_FF00, 16'd2, 16'd31, 16'd31);
    send_frame(1'b1);
    repeat (7) send_frame(1'b0);
    // flash with no cycles starts in steady
    configure(lffs_pkg::MODE_FLASH, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 16'd0, 16'd93, 16'd62);
    send_frame(1'b1);
    send_frame(1'b0);
    // fade with half-way rounding and clamping at both ends, runs out at the reversal
    configure(lffs_pkg::MODE_FADE, 32'h00FF_0010, 32'h0000_FF11, 16'd1, 16'd62, 16'd0);
    send_frame(1'b1);
    repeat (4) send_frame(1'b0);
    // fade with zero steps taken as one and zero count wrapping
    configure(lffs_pkg::MODE_FADE, 32'h0000_0000, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0);
    send_frame(1'b1);
    repeat (3) send_frame(1'b0);
    // unused selector, largest times and count
    configure(2'd3, 32'h8765_4321, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_frame(1'b1);
    send_frame(1'b0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 64; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 64; end
        default: begin tx_idle_pct = 15; rx_stall_pct = 15; end
      endcase
      for (int setting = 0; setting < 5; setting++) begin
        configure(2'($urandom_range(3)), rand_color(), rand_color(), rand_repeat(),
                  rand_ms(), rand_ms());
        send_frame(1'b1);
        // the receiver holds off while frames keep coming, so the input backs up
        if (phase == 0 && setting == 0) hold_req = hold_req + 1;
        run_frames(24);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && frames_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### led_flash_fade_sequencer.f
hw/rtl/lffs_pkg.sv
hw/rtl/lffs_div.sv
hw/rtl/lffs_datapath.sv
hw/rtl/lffs_ctrl.sv
hw/rtl/led_flash_fade_sequencer.sv
tb/lffs_frame_checker.sv
tb/led_flash_fade_sequencer_tb.sv
